FILE: rtl/core/crs_eval_pkg.sv
// Shared constants and arithmetic helpers for the Catmull-Rom segment evaluator.
// No dependencies; used by the RAM-fed pipeline in the top level.
`default_nettype none
package crs_eval_pkg;
  localparam int POINT_COUNT = 256;
  localparam int PTR_BITS    = $clog2(POINT_COUNT);
  localparam int STEP_COUNT  = 256;
  localparam int STEP_BITS   = $clog2(STEP_COUNT);
  localparam int COORD_BITS  = 24;
  localparam int OUT_BITS    = 26;
  // Working width for Bezier points and lerp results
  localparam int PT_BITS     = OUT_BITS;
  // Magnitude of a coordinate difference
  localparam int MAG_BITS    = COORD_BITS + 1;
  // Reciprocal of 6: ceil(2^DIV6_SHIFT / 6), exact for MAG_BITS magnitudes
  localparam int DIV6_SHIFT  = MAG_BITS + 3;
  localparam int DIV6_BITS   = DIV6_SHIFT - 1;
  localparam logic [DIV6_BITS-1:0] DIV6_MUL =
      DIV6_BITS'(((64'd1 << DIV6_SHIFT) + 64'd5) / 64'd6);
  localparam int PROD_BITS   = PT_BITS + 1 + STEP_BITS + 1;
  localparam int WORD_BITS   = 2 * COORD_BITS;

  typedef logic signed [PT_BITS-1:0]   pt_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // (b - a) * t, signed product
  function automatic prod_t lerp_mul(input pt_t a, input pt_t b,
                                     input logic [STEP_BITS-1:0] t);
    logic signed [PT_BITS:0]    d;
    logic signed [STEP_BITS:0]  ts;
    begin
      d  = {b[PT_BITS-1], b} - {a[PT_BITS-1], a};
      ts = {1'b0, t};
      lerp_mul = PROD_BITS'(d * ts);
    end
  endfunction

  // a + floor(prod / STEP_COUNT)
  function automatic pt_t lerp_add(input pt_t a, input prod_t p);
    prod_t sh;
    begin
      sh = p >>> STEP_BITS;
      lerp_add = PT_BITS'(a + PT_BITS'(sh));
    end
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/crs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module crs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/catmull_rom_segment_evaluator_top.sv
// Catmull-Rom segment evaluator: loads control points, evaluates curve points.
// Depends on crs_eval_pkg and crs_ram.
// Takes one item per cycle unless a waiting result holds the pipeline.
// Four replicated point RAMs give the four neighbor reads in the same cycle.
// Loads produce no result; the whole pipeline holds while the result waits.
// Reset clears the valid bits only; point RAM contents are undefined until loaded.
`default_nettype none
module catmull_rom_segment_evaluator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [7:0]  point_sel,
  input  wire logic [7:0]  step,
  input  wire logic signed [23:0] load_x,
  input  wire logic signed [23:0] load_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [25:0] curve_x,
  output logic signed [25:0] curve_y
);
  localparam int NS = 10;
  localparam int PB = crs_eval_pkg::PTR_BITS;
  localparam int CB = crs_eval_pkg::COORD_BITS;
  localparam int MB = crs_eval_pkg::MAG_BITS;
  localparam int SB = crs_eval_pkg::STEP_BITS;

  logic          adv;
  logic [NS-1:0] v;
  logic          acc;
  logic          ld;
  logic [PB-1:0] idx;
  logic [PB-1:0] raddr [4];
  logic [crs_eval_pkg::WORD_BITS-1:0] rd [4];

  assign adv      = ~v[NS-1] | out_ready;
  assign in_ready = adv;
  assign acc      = in_valid & in_ready;
  assign ld       = acc & (op == crs_eval_pkg::OP_LOAD);
  assign idx      = point_sel[PB-1:0];

  // Neighbor addresses wrap around the loop
  assign raddr[0] = idx - PB'(1);
  assign raddr[1] = idx;
  assign raddr[2] = idx + PB'(1);
  assign raddr[3] = idx + PB'(2);

  for (genvar k = 0; k < 4; k++) begin : g_ram
    crs_ram #(
      .WIDTH(crs_eval_pkg::WORD_BITS),
      .DEPTH(crs_eval_pkg::POINT_COUNT)
    ) u_ram (
      .clk  (clk),
      .we   (ld),
      .waddr(idx),
      .wdata({load_y[CB-1:0], load_x[CB-1:0]}),
      .re   (adv),
      .raddr(raddr[k]),
      .rdata(rd[k])
    );
  end

  // Valid bits advance with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NS-2:0], acc & (op == crs_eval_pkg::OP_EVAL)};
    end
  end

  // Step, saturated to the last step
  logic [SB-1:0] t_in;
  always_comb begin
    if ({1'b0, step} >= 9'(crs_eval_pkg::STEP_COUNT)) begin
      t_in = SB'(crs_eval_pkg::STEP_COUNT - 1);
    end else begin
      t_in = SB'(step);
    end
  end

  logic [SB-1:0] t [8];
  logic signed [CB-1:0] pw [4][2];
  logic signed [CB-1:0] cur2 [2], nxt2 [2], cur3 [2], nxt3 [2];
  logic [MB-1:0] mag_n [2], mag_c [2];
  logic          sg_n [2], sg_c [2], sg_n3 [2], sg_c3 [2];
  logic [MB-1:0] q_n [2], q_c [2];
  crs_eval_pkg::pt_t p0 [2], p1 [2], p2 [2], p3 [2];
  crs_eval_pkg::prod_t m1a [2], m1b [2], m1c [2];
  crs_eval_pkg::pt_t a1p0 [2], a1p1 [2], a1p2 [2];
  crs_eval_pkg::pt_t la [2], lb [2], lc [2];
  crs_eval_pkg::prod_t m2d [2], m2e [2];
  crs_eval_pkg::pt_t a2a [2], a2b [2];
  crs_eval_pkg::pt_t ld2 [2], le2 [2];
  crs_eval_pkg::prod_t m3 [2];
  crs_eval_pkg::pt_t a3 [2];
  crs_eval_pkg::pt_t res [2];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pw[k][0] = rd[k][CB-1:0];
      pw[k][1] = rd[k][2*CB-1:CB];
    end
  end

  // Step travels alongside the pipeline up to the last lerp stage
  always_ff @(posedge clk) begin
    if (adv) begin
      t[0] <= t_in;
      for (int s = 1; s < 8; s++) begin
        t[s] <= t[s-1];
      end
    end
  end

  // Datapath, one lane per axis
  always_ff @(posedge clk) begin
    logic signed [MB-1:0] dn;
    logic signed [MB-1:0] dc;
    logic [MB+crs_eval_pkg::DIV6_BITS-1:0] pr_n;
    logic [MB+crs_eval_pkg::DIV6_BITS-1:0] pr_c;
    crs_eval_pkg::pt_t qs_n;
    crs_eval_pkg::pt_t qs_c;
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        // Stage 2: neighbor differences as sign and magnitude
        dn = {pw[2][a][CB-1], pw[2][a]} - {pw[0][a][CB-1], pw[0][a]};
        dc = {pw[1][a][CB-1], pw[1][a]} - {pw[3][a][CB-1], pw[3][a]};
        sg_n[a]  <= dn[MB-1];
        sg_c[a]  <= dc[MB-1];
        mag_n[a] <= dn[MB-1] ? MB'(-dn) : MB'(dn);
        mag_c[a] <= dc[MB-1] ? MB'(-dc) : MB'(dc);
        cur2[a]  <= pw[1][a];
        nxt2[a]  <= pw[2][a];
        // Stage 3: divide magnitudes by six through the reciprocal
        pr_n = {{crs_eval_pkg::DIV6_BITS{1'b0}}, mag_n[a]}
               * {{MB{1'b0}}, crs_eval_pkg::DIV6_MUL};
        pr_c = {{crs_eval_pkg::DIV6_BITS{1'b0}}, mag_c[a]}
               * {{MB{1'b0}}, crs_eval_pkg::DIV6_MUL};
        q_n[a]   <= MB'(pr_n >> crs_eval_pkg::DIV6_SHIFT);
        q_c[a]   <= MB'(pr_c >> crs_eval_pkg::DIV6_SHIFT);
        sg_n3[a] <= sg_n[a];
        sg_c3[a] <= sg_c[a];
        cur3[a]  <= cur2[a];
        nxt3[a]  <= nxt2[a];
        // Stage 4: Bezier control points
        qs_n = crs_eval_pkg::PT_BITS'(q_n[a]);
        qs_c = crs_eval_pkg::PT_BITS'(q_c[a]);
        if (sg_n3[a]) qs_n = -qs_n;
        if (sg_c3[a]) qs_c = -qs_c;
        p0[a] <= crs_eval_pkg::PT_BITS'(cur3[a]);
        p3[a] <= crs_eval_pkg::PT_BITS'(nxt3[a]);
        p1[a] <= crs_eval_pkg::PT_BITS'(cur3[a]) + qs_n;
        p2[a] <= crs_eval_pkg::PT_BITS'(nxt3[a]) + qs_c;
        // Stages 5 and 6: first lerp level
        m1a[a]  <= crs_eval_pkg::lerp_mul(p0[a], p1[a], t[3]);
        m1b[a]  <= crs_eval_pkg::lerp_mul(p1[a], p2[a], t[3]);
        m1c[a]  <= crs_eval_pkg::lerp_mul(p2[a], p3[a], t[3]);
        a1p0[a] <= p0[a];
        a1p1[a] <= p1[a];
        a1p2[a] <= p2[a];
        la[a]   <= crs_eval_pkg::lerp_add(a1p0[a], m1a[a]);
        lb[a]   <= crs_eval_pkg::lerp_add(a1p1[a], m1b[a]);
        lc[a]   <= crs_eval_pkg::lerp_add(a1p2[a], m1c[a]);
        // Stages 7 and 8: second lerp level
        m2d[a]  <= crs_eval_pkg::lerp_mul(la[a], lb[a], t[5]);
        m2e[a]  <= crs_eval_pkg::lerp_mul(lb[a], lc[a], t[5]);
        a2a[a]  <= la[a];
        a2b[a]  <= lb[a];
        ld2[a]  <= crs_eval_pkg::lerp_add(a2a[a], m2d[a]);
        le2[a]  <= crs_eval_pkg::lerp_add(a2b[a], m2e[a]);
        // Stages 9 and 10: final lerp into the output register
        m3[a]   <= crs_eval_pkg::lerp_mul(ld2[a], le2[a], t[7]);
        a3[a]   <= ld2[a];
        res[a]  <= crs_eval_pkg::lerp_add(a3[a], m3[a]);
      end
    end
  end

  assign out_valid = v[NS-1];
  assign curve_x   = res[0];
  assign curve_y   = res[1];

  // A load never enters the result pipeline
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && op == crs_eval_pkg::OP_LOAD) |=> !v[0])
    else $error("load item entered result pipeline");

  // A stall freezes every valid bit
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v))
    else $error("valid bits moved during stall");

  // The item in the last inner stage reaches the output
  a_reach_out: assert property (@(posedge clk) disable iff (rst)
    (adv && v[NS-2]) |=> out_valid)
    else $error("item lost before output");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (v == '0))
    else $error("pipeline not empty after reset");
endmodule
`default_nettype wire
